// ----- design/wph_pkg.sv -----
package wph_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_RIFF  = 3'd1,
      ST_NO_WAVE  = 3'd2,
      ST_NO_FMT   = 3'd3,
      ST_FMT_SIZE = 3'd4,
      ST_NOT_PCM  = 3'd5,
      ST_NO_DATA  = 3'd6
   } status_type;

   // offsets of the final byte of each field within the canonical header
   localparam logic [5:0] POS_FMT_SIZE = 6'd19;
   localparam logic [5:0] POS_FORMAT   = 6'd21;
   localparam logic [5:0] POS_CHANNELS = 6'd23;
   localparam logic [5:0] POS_RATE     = 6'd27;
   localparam logic [5:0] POS_BYTERATE = 6'd31;
   localparam logic [5:0] POS_ALIGN    = 6'd33;
   localparam logic [5:0] POS_BITS     = 6'd35;
   localparam logic [5:0] POS_LAST     = 6'd43;

   localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
   localparam logic [15:0] FORMAT_PCM     = 16'd1;

   // "RIFF" "WAVE" "fmt " "data"
   localparam logic [7:0] TAG_CHARS [0:15] = '{
      8'h52, 8'h49, 8'h46, 8'h46,
      8'h57, 8'h41, 8'h56, 8'h45,
      8'h66, 8'h6d, 8'h74, 8'h20,
      8'h64, 8'h61, 8'h74, 8'h61
   };

   typedef struct packed {
      logic       hit;
      logic [1:0] idx;
   } tag_slot_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] fmt_code;
      logic [15:0] chan_count;
      logic [31:0] samp_rate;
      logic [31:0] bytes_per_sec;
      logic [15:0] frame_bytes;
      logic [15:0] samp_bits;
      logic [31:0] payload_len;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type res;
   } step_type;

   function automatic tag_slot_type tag_slot(input logic [5:0] pos);
      tag_slot_type s;
      s.hit = 1'b1;
      s.idx = 2'd0;
      case (pos) inside
         [6'd0:6'd3]:   s.idx = 2'd0;
         [6'd8:6'd11]:  s.idx = 2'd1;
         [6'd12:6'd15]: s.idx = 2'd2;
         [6'd36:6'd39]: s.idx = 2'd3;
         default:       s.hit = 1'b0;
      endcase
      return s;
   endfunction

   function automatic status_type tag_status(input logic [1:0] idx);
      status_type st;
      case (idx)
         2'd0:    st = ST_NO_RIFF;
         2'd1:    st = ST_NO_WAVE;
         2'd2:    st = ST_NO_FMT;
         default: st = ST_NO_DATA;
      endcase
      return st;
   endfunction

endpackage

// ----- design/wph_parser.sv -----
module wph_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [7:0]        byte_value,
   input  logic              first,
   output wph_pkg::step_type step
);

   logic [5:0]  pos_ff, pos_in;
   logic        active_ff, active_in;
   logic        tm_ff, tm_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;

   logic                  act;
   logic [5:0]            pos;
   logic                  tm_base;
   logic                  diff;
   logic                  emit;
   wph_pkg::status_type   status;
   logic [31:0]           dsize;
   wph_pkg::tag_slot_type slot;

   always_comb begin
      act     = first | active_ff;
      pos     = first ? 6'd0 : pos_ff;
      tm_base = first ? 1'b0 : tm_ff;
      acc_in  = {byte_value, (first ? 24'd0 : acc_ff[31:8])};
      fmt_in   = first ? 16'd0 : fmt_ff;
      chan_in  = first ? 16'd0 : chan_ff;
      rate_in  = first ? 32'd0 : rate_ff;
      brate_in = first ? 32'd0 : brate_ff;
      align_in = first ? 16'd0 : align_ff;
      bits_in  = first ? 16'd0 : bits_ff;
      emit   = 1'b0;
      status = wph_pkg::ST_OK;
      dsize  = 32'd0;
      tm_in  = tm_base;
      diff   = 1'b0;

      slot = wph_pkg::tag_slot(pos);
      if (slot.hit) begin
         diff  = byte_value != wph_pkg::TAG_CHARS[{slot.idx, pos[1:0]}];
         tm_in = (pos[1:0] == 2'd0) ? diff : (tm_base | diff);
         if (pos[1:0] == 2'd3 && tm_in) begin
            emit   = 1'b1;
            status = wph_pkg::tag_status(slot.idx);
         end
      end

      if (!emit) begin
         case (pos)
            wph_pkg::POS_FMT_SIZE: begin
               if (acc_in != wph_pkg::FMT_CHUNK_SIZE) begin
                  emit   = 1'b1;
                  status = wph_pkg::ST_FMT_SIZE;
               end
            end
            wph_pkg::POS_FORMAT: begin
               fmt_in = acc_in[31:16];
               if (acc_in[31:16] != wph_pkg::FORMAT_PCM) begin
                  emit   = 1'b1;
                  status = wph_pkg::ST_NOT_PCM;
               end
            end
            wph_pkg::POS_CHANNELS: chan_in  = acc_in[31:16];
            wph_pkg::POS_RATE:     rate_in  = acc_in;
            wph_pkg::POS_BYTERATE: brate_in = acc_in;
            wph_pkg::POS_ALIGN:    align_in = acc_in[31:16];
            wph_pkg::POS_BITS:     bits_in  = acc_in[31:16];
            wph_pkg::POS_LAST: begin
               emit  = 1'b1;
               dsize = acc_in;
            end
            default: ;
         endcase
      end

      active_in = ~emit;
      pos_in    = emit ? pos : pos + 6'd1;
   end

   always_comb begin
      step.emit              = en & act & emit;
      step.res.status        = status;
      step.res.fmt_code      = fmt_in;
      step.res.chan_count    = chan_in;
      step.res.samp_rate     = rate_in;
      step.res.bytes_per_sec = brate_in;
      step.res.frame_bytes   = align_in;
      step.res.samp_bits     = bits_in;
      step.res.payload_len   = dsize;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= 6'd0;
         tm_ff     <= 1'b0;
      end else if (en && act) begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         tm_ff     <= tm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && act) begin
         acc_ff   <= acc_in;
         fmt_ff   <= fmt_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         brate_ff <= brate_in;
         align_ff <= align_in;
         bits_ff  <= bits_in;
      end
   end

endmodule

// ----- design/wph_out_reg.sv -----
module wph_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  wph_pkg::step_type   step,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                can_load,
   output wph_pkg::result_type res
);

   logic                valid_ff, valid_in;
   wph_pkg::result_type res_ff;

   // a held result leaves on the same edge a new one may be loaded
   assign can_load = ~valid_ff | rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = step.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.emit) begin
         res_ff <= step.res;
      end
   end

   assign rsp_valid = valid_ff;
   assign res       = res_ff;

endmodule

// ----- design/wav_pcm_header_parser.sv -----
// A result is registered and appears in the cycle after the byte transfer that causes it.
// Throughput: one header byte per cycle; the byte path stalls only while a
// result sits in the output register and rsp_ready is low.
// Reset (synchronous, active high) leaves the parser idle with no result held;
// bytes are ignored until one arrives with req_first set.
module wav_pcm_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_fmt_code,
   output logic [15:0] rsp_chan_count,
   output logic [31:0] rsp_samp_rate,
   output logic [31:0] rsp_bytes_per_sec,
   output logic [15:0] rsp_frame_bytes,
   output logic [15:0] rsp_samp_bits,
   output logic [31:0] rsp_payload_len
);

   wph_pkg::step_type   step;
   wph_pkg::result_type res;
   logic                can_load;
   logic                accept;

   assign req_ready = can_load;
   assign accept    = req_valid & can_load;

   wph_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .en         (accept),
      .byte_value (req_byte_value),
      .first      (req_first),
      .step       (step)
   );

   wph_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .res       (res)
   );

   assign rsp_status        = res.status;
   assign rsp_fmt_code      = res.fmt_code;
   assign rsp_chan_count    = res.chan_count;
   assign rsp_samp_rate     = res.samp_rate;
   assign rsp_bytes_per_sec = res.bytes_per_sec;
   assign rsp_frame_bytes   = res.frame_bytes;
   assign rsp_samp_bits     = res.samp_bits;
   assign rsp_payload_len   = res.payload_len;

endmodule

// ----- tb/tb.sv -----
module tb;

   typedef enum int {
      FLAW_NONE,
      FLAW_RIFF,
      FLAW_WAVE,
      FLAW_FMT,
      FLAW_SIZE,
      FLAW_FORMAT,
      FLAW_DATA
   } flaw_type;

   // Tracks the parser's view of the byte stream and keeps the header summaries still owed.
   class header_tracker_type;
      logic [5:0]          pos = '0;
      bit                  busy = 1'b0;
      bit                  tag_bad = 1'b0;
      logic [31:0]         window = '0;
      wph_pkg::result_type held = '0;
      wph_pkg::result_type expected_summaries[$];
      int                  mismatches = 0;

      function void close(wph_pkg::status_type st, logic [31:0] size);
         wph_pkg::result_type r;
         r = held;
         r.status = st;
         r.payload_len = size;
         expected_summaries.push_back(r);
         busy = 1'b0;
      endfunction

      // Returns 1 when the byte is taken into a header, 0 when the parser ignores it.
      function bit note_byte(logic [7:0] b, logic first_flag);
         int   slot;
         logic diff;
         if (first_flag) begin
            pos = '0;
            tag_bad = 1'b0;
            window = '0;
            held = '0;
            busy = 1'b1;
         end else if (!busy) begin
            return 1'b0;
         end
         window = {b, window[31:8]};
         slot = -1;
         if (pos <= 6'd3) slot = 0;
         else if (pos >= 6'd8 && pos <= 6'd11) slot = 1;
         else if (pos >= 6'd12 && pos <= 6'd15) slot = 2;
         else if (pos >= 6'd36 && pos <= 6'd39) slot = 3;
         if (slot >= 0) begin
            diff = (b != wph_pkg::TAG_CHARS[slot * 4 + pos[1:0]]);
            tag_bad = (pos[1:0] == 2'd0) ? diff : (tag_bad | diff);
            // a tag is only judged once its fourth character is in
            if (pos[1:0] == 2'd3 && tag_bad) begin
               case (slot)
                  0: close(wph_pkg::ST_NO_RIFF, '0);
                  1: close(wph_pkg::ST_NO_WAVE, '0);
                  2: close(wph_pkg::ST_NO_FMT, '0);
                  default: close(wph_pkg::ST_NO_DATA, '0);
               endcase
               return 1'b1;
            end
         end
         case (pos)
            wph_pkg::POS_FMT_SIZE: begin
               if (window != wph_pkg::FMT_CHUNK_SIZE) begin
                  close(wph_pkg::ST_FMT_SIZE, '0);
                  return 1'b1;
               end
            end
            wph_pkg::POS_FORMAT: begin
               held.fmt_code = window[31:16];
               if (held.fmt_code != wph_pkg::FORMAT_PCM) begin
                  close(wph_pkg::ST_NOT_PCM, '0);
                  return 1'b1;
               end
            end
            wph_pkg::POS_CHANNELS: held.chan_count = window[31:16];
            wph_pkg::POS_RATE: held.samp_rate = window;
            wph_pkg::POS_BYTERATE: held.bytes_per_sec = window;
            wph_pkg::POS_ALIGN: held.frame_bytes = window[31:16];
            wph_pkg::POS_BITS: held.samp_bits = window[31:16];
            wph_pkg::POS_LAST: begin
               close(wph_pkg::ST_OK, window);
               return 1'b1;
            end
            default: ;
         endcase
         pos = pos + 6'd1;
         return 1'b1;
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_summary(wph_pkg::result_type got);
         wph_pkg::result_type want;
         if (expected_summaries.size() == 0) begin
            $error("summary transfer with none outstanding (status %0d)", got.status);
            mismatches++;
            return;
         end
         want = expected_summaries.pop_front();
         compare("status", 32'(want.status), 32'(got.status));
         compare("fmt_code", 32'(want.fmt_code), 32'(got.fmt_code));
         compare("chan_count", 32'(want.chan_count), 32'(got.chan_count));
         compare("samp_rate", want.samp_rate, got.samp_rate);
         compare("bytes_per_sec", want.bytes_per_sec, got.bytes_per_sec);
         compare("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
         compare("samp_bits", 32'(want.samp_bits), 32'(got.samp_bits));
         compare("payload_len", want.payload_len, got.payload_len);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_value = '0;
   logic        req_first = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_fmt_code;
   logic [15:0] rsp_chan_count;
   logic [31:0] rsp_samp_rate;
   logic [31:0] rsp_bytes_per_sec;
   logic [15:0] rsp_frame_bytes;
   logic [15:0] rsp_samp_bits;
   logic [31:0] rsp_payload_len;

   header_tracker_type  tracker = new();
   wph_pkg::result_type seen;
   logic [7:0]          hdr_bytes [0:43];
   int                  field_mode = 0;   // 0 mixed, 1 all zero, 2 all ones
   int                  taken = 0;
   bit                  steady = 1'b0;
   bit                  hold_req = 1'b0;
   bit                  hold_done = 1'b0;
   int                  hold_left = 0;

   wav_pcm_header_parser u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_value    (req_byte_value),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_fmt_code      (rsp_fmt_code),
      .rsp_chan_count    (rsp_chan_count),
      .rsp_samp_rate     (rsp_samp_rate),
      .rsp_bytes_per_sec (rsp_bytes_per_sec),
      .rsp_frame_bytes   (rsp_frame_bytes),
      .rsp_samp_bits     (rsp_samp_bits),
      .rsp_payload_len   (rsp_payload_len)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // summary sink: random back-pressure plus one long hold that stalls the byte path
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.status = wph_pkg::status_type'(rsp_status);
         seen.fmt_code = rsp_fmt_code;
         seen.chan_count = rsp_chan_count;
         seen.samp_rate = rsp_samp_rate;
         seen.bytes_per_sec = rsp_bytes_per_sec;
         seen.frame_bytes = rsp_frame_bytes;
         seen.samp_bits = rsp_samp_bits;
         seen.payload_len = rsp_payload_len;
         tracker.check_summary(seen);
      end
   end

   function automatic logic [31:0] pick_word();
      if (field_mode == 1) return '0;
      if (field_mode == 2) return '1;
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 32'($urandom_range(255));
         default: return $urandom;
      endcase
   endfunction

   task automatic put_le(input int at, input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) hdr_bytes[at + i] = v[8 * i +: 8];
   endtask

   task automatic compose_header(input flaw_type flaw);
      logic [31:0] w;
      for (int k = 0; k < 4; k++) begin
         hdr_bytes[k] = wph_pkg::TAG_CHARS[k];
         hdr_bytes[8 + k] = wph_pkg::TAG_CHARS[4 + k];
         hdr_bytes[12 + k] = wph_pkg::TAG_CHARS[8 + k];
         hdr_bytes[36 + k] = wph_pkg::TAG_CHARS[12 + k];
      end
      put_le(4, pick_word(), 4);
      put_le(16, wph_pkg::FMT_CHUNK_SIZE, 4);
      put_le(20, 32'(wph_pkg::FORMAT_PCM), 2);
      put_le(22, pick_word(), 2);
      put_le(24, pick_word(), 4);
      put_le(28, pick_word(), 4);
      put_le(32, pick_word(), 2);
      put_le(34, pick_word(), 2);
      put_le(40, pick_word(), 4);
      w = $urandom_range(1) ? $urandom : 32'($urandom_range(1, 255));
      if (w == '0) w = 32'd1;
      case (flaw)
         FLAW_RIFF: hdr_bytes[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
         FLAW_WAVE: hdr_bytes[8 + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
         FLAW_FMT: hdr_bytes[12 + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
         FLAW_DATA: hdr_bytes[36 + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
         FLAW_SIZE: put_le(16, wph_pkg::FMT_CHUNK_SIZE ^ w, 4);
         FLAW_FORMAT:
            put_le(20, 32'(wph_pkg::FORMAT_PCM) ^ (w[15:0] == '0 ? 32'd2 : w), 2);
         default: ;
      endcase
   endtask

   // Called just after a rising edge; returns just after the edge of the transfer.
   task automatic send_byte(input logic [7:0] value, input logic first_flag);
      if (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= value;
      req_first <= first_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(tracker.note_byte(value, first_flag));
      taken++;
   endtask

   task automatic send_header(input int count);
      for (int i = 0; i < count; i++) send_byte(hdr_bytes[i], i == 0);
   endtask

   task automatic wait_drained();
      if (tracker.expected_summaries.size() != 0) begin
         req_valid <= 1'b0;
         while (tracker.expected_summaries.size() != 0) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      flaw_type flaw;
      int       cut;
      int       roll;
      int       headers;
      headers = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // stray bytes straight after reset are ignored
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h52, 1'b0);
      field_mode = 1;
      compose_header(FLAW_NONE);
      send_header(44);
      field_mode = 2;
      compose_header(FLAW_NONE);
      send_header(44);
      field_mode = 0;
      // bad first byte; the RIFF tag fails at its fourth byte and the rest of the header falls on an idle parser
      compose_header(FLAW_NONE);
      hdr_bytes[0] = 8'h00;
      send_header(44);
      compose_header(FLAW_NONE);
      hdr_bytes[11] = 8'hC5;
      send_header(12);
      compose_header(FLAW_FMT);
      send_header(16);
      compose_header(FLAW_SIZE);
      send_header(20);
      compose_header(FLAW_NONE);
      put_le(20, 32'h0000_FFFF, 2);
      send_header(22);
      compose_header(FLAW_DATA);
      send_header(44);
      // restart part way through a header
      compose_header(FLAW_NONE);
      send_header(30);
      compose_header(FLAW_NONE);
      send_header(44);
      send_byte(8'h52, 1'b0);
      wait_drained();

      hold_req <= 1'b1;
      while (taken < 1200) begin
         if ($urandom_range(99) < 55) flaw = FLAW_NONE;
         else flaw = flaw_type'($urandom_range(1, 6));
         compose_header(flaw);
         cut = 44;
         roll = $urandom_range(99);
         if (roll < 10) cut = $urandom_range(1, 43);
         else if (flaw != FLAW_NONE && roll < 50) cut = $urandom_range(1, 44);
         send_header(cut);
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(9) == 0);
         end
         headers++;
         steady <= (headers >= 10 && headers < 16);
         if (headers % 9 == 0) wait_drained();
      end

      req_valid <= 1'b0;
      while (tracker.expected_summaries.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_summaries.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
